// ===== design/tmws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmws_pkg
// Shared constants, codes and defaults of the trigram word sampler.
// ----------------------------------------------------------------------------
package tmws_pkg;

   localparam int ALPHABET_DEF    = 26;
   localparam int RETRY_LIMIT_DEF = 10;
   localparam int COUNT_BITS_DEF  = 16;

   localparam int FUNC_W   = 2;
   localparam int LETTER_W = 5;
   localparam int RAND_W   = 32;
   localparam int EVENT_W  = 3;
   localparam int LENGTH_W = 7;
   localparam int CFG_W    = 6;

   localparam logic [FUNC_W-1:0] FUNC_CLEAR     = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TRAIN_LTR = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TRAIN_END = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_GENERATE  = 2'd3;

   localparam logic [EVENT_W-1:0] EV_ACK     = 3'd0;
   localparam logic [EVENT_W-1:0] EV_LETTER  = 3'd1;
   localparam logic [EVENT_W-1:0] EV_DONE    = 3'd2;
   localparam logic [EVENT_W-1:0] EV_REJECT  = 3'd3;
   localparam logic [EVENT_W-1:0] EV_RESTART = 3'd4;
   localparam logic [EVENT_W-1:0] EV_EMPTY   = 3'd5;

   localparam logic CSR_MIN_LENGTH = 1'b0;
   localparam logic CSR_MAX_LENGTH = 1'b1;

   localparam logic [CFG_W-1:0] MIN_LENGTH_RST = 6'd0;
   localparam logic [CFG_W-1:0] MAX_LENGTH_RST = 6'd12;

endpackage
`default_nettype wire

// ===== design/tmws_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmws_div
// Restoring remainder unit: one dividend bit per cycle, over all RAND_W dividend bits.
// ----------------------------------------------------------------------------
module tmws_div #(
   parameter int COUNT_BITS = tmws_pkg::COUNT_BITS_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             start,
   input  wire  [tmws_pkg::RAND_W-1:0]     dividend,
   input  wire  [COUNT_BITS-1:0]           divisor,
   output logic                            done,
   output logic [COUNT_BITS-1:0]           remainder
);
   import tmws_pkg::*;

   localparam int CNT_W = $clog2(RAND_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [RAND_W-1:0]     dvd_ff, dvd_in;
   logic [COUNT_BITS-1:0] dsr_ff, dsr_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [COUNT_BITS:0]   trial;
   logic [COUNT_BITS:0]   diff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[RAND_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[RAND_W-2:0], 1'b0};
         rem_in = trial >= {1'b0, dsr_ff} ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(RAND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("remainder done without a running division");
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < dsr_ff)
      else $error("remainder not below divisor");
   a_no_restart_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start |=> busy_ff || done_ff)
      else $error("division stopped without done");

endmodule
`default_nettype wire

// ===== design/trigram_markov_word_sampler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trigram_markov_word_sampler
// Trigram letter model in two synchronous memories; trains and samples words.
// ----------------------------------------------------------------------------
// Steps per function: train reads and writes back its counts; empty-context
// generate skips the remainder unit; generate runs the remainder unit, then one count
// read per symbol walked; clear sweeps 2**(3*SW) addresses, SW = clog2(ALPHABET+1).
// One item at a time: the next beat is taken in the cycle after the response loads.
// Reset runs the same clearing pass over the count memory before the first item
// is accepted; no beat is produced for it.
module trigram_markov_word_sampler #(
   parameter int ALPHABET    = tmws_pkg::ALPHABET_DEF,
   parameter int RETRY_LIMIT = tmws_pkg::RETRY_LIMIT_DEF,
   parameter int COUNT_BITS  = tmws_pkg::COUNT_BITS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,   // func[1:0], letter[6:2], rand_value[38:7]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // event_res[2:0], out_letter[7:3], word_length[14:8]
   input  wire         csr_we,
   input  wire         csr_addr,
   input  wire  [tmws_pkg::CFG_W-1:0] csr_wdata
);
   import tmws_pkg::*;

   localparam int SW     = $clog2(ALPHABET + 1);
   localparam int CTX_W  = 2 * SW;
   localparam int ADDR_W = 3 * SW;
   localparam logic [SW-1:0] BOUND = SW'(ALPHABET);
   localparam logic [SW-1:0] LAST  = SW'(ALPHABET - 1);
   localparam int RTY_W  = 4;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_TRAIN = 7'b0000100,
      S_GTOT  = 7'b0001000,
      S_GDIV  = 7'b0010000,
      S_WALK  = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [FUNC_W-1:0]   req_func;
   logic [LETTER_W-1:0] req_letter;
   logic [RAND_W-1:0]   req_rand;
   logic                accept;
   logic                ltr_ok;

   logic [CFG_W-1:0] min_len_ff, max_len_ff;

   logic [SW-1:0]       tr_prev_ff, tr_prev_in, tr_cur_ff, tr_cur_in;
   logic [SW-1:0]       g_prev_ff, g_prev_in, g_cur_ff, g_cur_in;
   logic [LENGTH_W-1:0] g_len_ff, g_len_in;
   logic [RTY_W-1:0]    retry_ff, retry_in;
   logic                vowel_ff, vowel_in;

   logic [ADDR_W-1:0]     sweep_ff, sweep_in;
   logic                  clr_rsp_ff, clr_rsp_in;
   logic [ADDR_W-1:0]     tr_addr_ff, tr_addr_in;
   logic [RAND_W-1:0]     rand_ff, rand_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [SW-1:0]         issue_ff, issue_in, cmp_ff, cmp_in;
   logic                  rdv_ff, rdv_in;

   logic [EVENT_W-1:0]  res_ev_ff, res_ev_in;
   logic [LETTER_W-1:0] res_ltr_ff, res_ltr_in;
   logic [LENGTH_W-1:0] res_len_ff, res_len_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         rsp_data_ff, rsp_data_in;

   logic [COUNT_BITS-1:0] count_mem [2**ADDR_W];
   logic [COUNT_BITS-1:0] total_mem [2**CTX_W];
   logic [COUNT_BITS-1:0] cnt_rd_ff, tot_rd_ff;
   logic [ADDR_W-1:0]     cnt_raddr, cnt_waddr;
   logic [CTX_W-1:0]      tot_raddr, tot_waddr;
   logic [COUNT_BITS-1:0] cnt_wdata, tot_wdata;
   logic                  mem_we;

   logic                  div_start, div_done;
   logic [COUNT_BITS-1:0] div_rem;

   logic                  hit;
   logic [SW-1:0]         pick;
   logic [RTY_W-1:0]      retry_nx;
   logic [LENGTH_W-1:0]   len_nx;

   assign req_func   = req_tdata[1:0];
   assign req_letter = req_tdata[6:2];
   assign req_rand   = req_tdata[38:7];
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign ltr_ok     = int'(req_letter) < ALPHABET;

   tmws_div #(.COUNT_BITS(COUNT_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (rand_ff),
      .divisor   (tot_rd_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      cnt_raddr = {tr_prev_ff, tr_cur_ff, (req_func == FUNC_TRAIN_END) ? BOUND : SW'(req_letter)};
      tot_raddr = (req_func == FUNC_GENERATE) ? {g_prev_ff, g_cur_ff} : {tr_prev_ff, tr_cur_ff};
      if (state_ff == S_WALK) begin
         cnt_raddr = {g_prev_ff, g_cur_ff, issue_ff};
      end
      mem_we    = 1'b0;
      cnt_waddr = tr_addr_ff;
      tot_waddr = tr_addr_ff[ADDR_W-1:SW];
      cnt_wdata = cnt_rd_ff + 1'b1;
      tot_wdata = tot_rd_ff + 1'b1;
      if (state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         cnt_waddr = sweep_ff;
         tot_waddr = sweep_ff[CTX_W-1:0];
         cnt_wdata = '0;
         tot_wdata = '0;
      end else if (state_ff == S_TRAIN) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_mem[cnt_waddr] <= cnt_wdata;
         total_mem[tot_waddr] <= tot_wdata;
      end
      cnt_rd_ff <= count_mem[cnt_raddr];
      tot_rd_ff <= total_mem[tot_raddr];
   end

   always_comb begin
      state_in   = state_ff;
      tr_prev_in = tr_prev_ff;
      tr_cur_in  = tr_cur_ff;
      g_prev_in  = g_prev_ff;
      g_cur_in   = g_cur_ff;
      g_len_in   = g_len_ff;
      retry_in   = retry_ff;
      vowel_in   = vowel_ff;
      sweep_in   = sweep_ff;
      clr_rsp_in = clr_rsp_ff;
      tr_addr_in = tr_addr_ff;
      rand_in    = rand_ff;
      rem_in     = rem_ff;
      issue_in   = issue_ff;
      cmp_in     = cmp_ff;
      rdv_in     = rdv_ff;
      res_ev_in  = res_ev_ff;
      res_ltr_in = res_ltr_ff;
      res_len_in = res_len_ff;
      div_start  = 1'b0;
      hit        = 1'b0;
      pick       = BOUND;
      retry_nx   = retry_ff + 1'b1;
      len_nx     = g_len_ff + 1'b1;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_CLEAR: begin
            sweep_in = sweep_ff + 1'b1;
            if (&sweep_ff) begin
               res_ev_in  = EV_ACK;
               res_ltr_in = '0;
               res_len_in = '0;
               state_in   = clr_rsp_ff ? S_OUT : S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               rand_in    = req_rand;
               res_ev_in  = EV_ACK;
               res_ltr_in = '0;
               res_len_in = g_len_ff;
               tr_addr_in = cnt_raddr;
               case (req_func)
                  FUNC_CLEAR: begin
                     tr_prev_in = BOUND;
                     tr_cur_in  = BOUND;
                     g_prev_in  = BOUND;
                     g_cur_in   = BOUND;
                     g_len_in   = '0;
                     retry_in   = '0;
                     vowel_in   = 1'b0;
                     sweep_in   = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = S_CLEAR;
                  end
                  FUNC_TRAIN_LTR: begin
                     if (ltr_ok) begin
                        tr_prev_in = tr_cur_ff;
                        tr_cur_in  = SW'(req_letter);
                        state_in   = S_TRAIN;
                     end else begin
                        state_in = S_OUT;
                     end
                  end
                  FUNC_TRAIN_END: begin
                     tr_prev_in = BOUND;
                     tr_cur_in  = BOUND;
                     state_in   = S_TRAIN;
                  end
                  default: state_in = S_GTOT;
               endcase
            end
         end
         S_TRAIN: state_in = S_OUT;
         S_GTOT: begin
            if (tot_rd_ff == '0) begin
               res_ev_in = EV_EMPTY;
               state_in  = S_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = S_GDIV;
            end
         end
         S_GDIV: begin
            if (div_done) begin
               rem_in   = div_rem;
               issue_in = '0;
               rdv_in   = 1'b0;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            // Reads are issued one symbol ahead of the compare.
            issue_in = issue_ff + 1'b1;
            cmp_in   = issue_ff;
            rdv_in   = 1'b1;
            if (rdv_ff) begin
               if (rem_ff < cnt_rd_ff) begin
                  hit  = 1'b1;
                  pick = cmp_ff;
               end else begin
                  rem_in = rem_ff - cnt_rd_ff;
                  if (cmp_ff == LAST) begin
                     hit = 1'b1;
                  end
               end
            end
            if (hit) begin
               state_in = S_OUT;
               if (pick == BOUND) begin
                  if (g_len_ff >= LENGTH_W'(min_len_ff) && vowel_ff) begin
                     res_ev_in = EV_DONE;
                     g_prev_in = BOUND;
                     g_cur_in  = BOUND;
                     g_len_in  = '0;
                     retry_in  = '0;
                     vowel_in  = 1'b0;
                  end else if (int'(retry_nx) >= RETRY_LIMIT) begin
                     res_ev_in  = EV_RESTART;
                     res_len_in = '0;
                     g_prev_in  = BOUND;
                     g_cur_in   = BOUND;
                     g_len_in   = '0;
                     retry_in   = '0;
                     vowel_in   = 1'b0;
                  end else begin
                     res_ev_in = EV_REJECT;
                     retry_in  = retry_nx;
                  end
               end else if (len_nx > LENGTH_W'(max_len_ff)) begin
                  res_ev_in  = EV_RESTART;
                  res_len_in = '0;
                  g_prev_in  = BOUND;
                  g_cur_in   = BOUND;
                  g_len_in   = '0;
                  retry_in   = '0;
                  vowel_in   = 1'b0;
               end else begin
                  res_ev_in  = EV_LETTER;
                  res_ltr_in = LETTER_W'(pick);
                  res_len_in = len_nx;
                  g_len_in   = len_nx;
                  g_prev_in  = g_cur_ff;
                  g_cur_in   = pick;
                  vowel_in   = vowel_ff || pick == SW'(0) || pick == SW'(4) ||
                               pick == SW'(8) || pick == SW'(14) || pick == SW'(20);
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, res_len_ff, res_ltr_ff, res_ev_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         clr_rsp_ff   <= 1'b0;
         tr_prev_ff   <= BOUND;
         tr_cur_ff    <= BOUND;
         g_prev_ff    <= BOUND;
         g_cur_ff     <= BOUND;
         g_len_ff     <= '0;
         retry_ff     <= '0;
         vowel_ff     <= 1'b0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         min_len_ff   <= MIN_LENGTH_RST;
         max_len_ff   <= MAX_LENGTH_RST;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         clr_rsp_ff   <= clr_rsp_in;
         tr_prev_ff   <= tr_prev_in;
         tr_cur_ff    <= tr_cur_in;
         g_prev_ff    <= g_prev_in;
         g_cur_ff     <= g_cur_in;
         g_len_ff     <= g_len_in;
         retry_ff     <= retry_in;
         vowel_ff     <= vowel_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_MIN_LENGTH: min_len_ff <= csr_wdata;
               CSR_MAX_LENGTH: max_len_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      tr_addr_ff  <= tr_addr_in;
      rand_ff     <= rand_in;
      rem_ff      <= rem_in;
      issue_ff    <= issue_in;
      cmp_ff      <= cmp_in;
      res_ev_ff   <= res_ev_in;
      res_ltr_ff  <= res_ltr_in;
      res_len_ff  <= res_len_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_len_bounded: assert property (@(posedge clock) disable iff (reset)
      g_len_ff <= LENGTH_W'(2**CFG_W - 1))
      else $error("generated word length out of range");
   a_retry_bounded: assert property (@(posedge clock) disable iff (reset)
      int'(retry_ff) < RETRY_LIMIT)
      else $error("retry count reached its limit without restart");
   a_walk_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_GTOT && tot_rd_ff != '0 |=> state_ff == S_GDIV)
      else $error("nonempty context did not start the remainder unit");
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_GDIV)
      else $error("remainder result arrived outside the generate step");

endmodule
`default_nettype wire

// ===== dv/trigram_markov_word_sampler_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trigram word sampler testbench
// Trains the letter model with short words, then samples words from it under
// random stream gaps and stalls, and checks each response beat against a
// behavioral model of the count tables and the word generation rules.
// ----------------------------------------------------------------------------
module trigram_markov_word_sampler_test;
   import tmws_pkg::*;

   localparam int SYMS     = ALPHABET_DEF + 1;
   localparam int BOUNDARY = ALPHABET_DEF;
   localparam int CLEAR_WAIT = 33000;

   typedef struct packed {
      logic [RAND_W-1:0]   rand_value;
      logic [LETTER_W-1:0] letter;
      logic [FUNC_W-1:0]   func;
   } req_item_type;

   typedef struct packed {
      logic [LENGTH_W-1:0] word_length;
      logic [4:0]          out_letter;
      logic [EVENT_W-1:0]  event_res;
   } rsp_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic        csr_addr = 1'b0;
   logic [CFG_W-1:0] csr_wdata = '0;

   trigram_markov_word_sampler i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Model state.
   logic [15:0] trigram_count [SYMS*SYMS*SYMS];
   logic [15:0] context_total [SYMS*SYMS];
   int unsigned train_prev, train_cur, gen_prev, gen_cur, gen_len, retries;
   bit          vowel_seen;
   int unsigned min_len, max_len;

   req_item_type pending_items [$];
   rsp_item_type expected_events [$];
   int errors = 0;
   int accepted = 0;
   int checked = 0;
   int words_done = 0;
   bit hold_sender = 1'b0;
   int event_seen [8];

   function automatic bit is_vowel(int unsigned s);
      return s == 0 || s == 4 || s == 8 || s == 14 || s == 20;
   endfunction

   function automatic void restart_word();
      gen_prev = BOUNDARY; gen_cur = BOUNDARY;
      gen_len = 0; retries = 0; vowel_seen = 1'b0;
   endfunction

   function automatic void clear_model();
      foreach (trigram_count[i]) trigram_count[i] = '0;
      foreach (context_total[i]) context_total[i] = '0;
      train_prev = BOUNDARY; train_cur = BOUNDARY;
      restart_word();
   endfunction

   function automatic void count_next(int unsigned n);
      int unsigned ctx;
      ctx = train_prev * SYMS + train_cur;
      trigram_count[ctx*SYMS+n] = trigram_count[ctx*SYMS+n] + 16'd1;
      context_total[ctx] = context_total[ctx] + 16'd1;
   endfunction

   function automatic rsp_item_type predict_event(req_item_type it);
      rsp_item_type r;
      int unsigned ctx, n;
      longint unsigned rem;
      r = '0;
      case (it.func)
         FUNC_CLEAR: begin
            clear_model();
            r.word_length = '0;
         end
         FUNC_TRAIN_LTR: begin
            if (it.letter < ALPHABET_DEF) begin
               count_next(it.letter);
               train_prev = train_cur;
               train_cur = it.letter;
            end
            r.word_length = 7'(gen_len);
         end
         FUNC_TRAIN_END: begin
            count_next(BOUNDARY);
            train_prev = BOUNDARY; train_cur = BOUNDARY;
            r.word_length = 7'(gen_len);
         end
         default: begin
            ctx = gen_prev * SYMS + gen_cur;
            if (context_total[ctx] == 0) begin
               r.event_res = EV_EMPTY;
               r.word_length = 7'(gen_len);
            end else begin
               rem = it.rand_value % context_total[ctx];
               n = 0;
               while (n < BOUNDARY && rem >= trigram_count[ctx*SYMS+n]) begin
                  rem -= trigram_count[ctx*SYMS+n];
                  n++;
               end
               if (n == BOUNDARY) begin
                  if (gen_len >= min_len && vowel_seen) begin
                     r.event_res = EV_DONE;
                     r.word_length = 7'(gen_len);
                     restart_word();
                  end else begin
                     retries++;
                     if (retries >= RETRY_LIMIT_DEF) begin
                        r.event_res = EV_RESTART;
                        restart_word();
                     end else begin
                        r.event_res = EV_REJECT;
                        r.word_length = 7'(gen_len);
                     end
                  end
               end else begin
                  gen_len++;
                  if (gen_len > max_len) begin
                     r.event_res = EV_RESTART;
                     restart_word();
                  end else begin
                     if (is_vowel(n)) vowel_seen = 1'b1;
                     gen_prev = gen_cur; gen_cur = n;
                     r.event_res = EV_LETTER;
                     r.out_letter = 5'(n);
                     r.word_length = 7'(gen_len);
                  end
               end
            end
         end
      endcase
      return r;
   endfunction

   // Driver: bursts of beats separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_events.push_back(predict_event(req_item_type'(req_tdata[38:0])));
            accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0 || hold_sender || pending_items.size() == 0) begin
               req_tvalid <= 1'b0;
               if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata <= {1'b0, pending_items.pop_front()};
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // Monitor with its own stall pattern: long ready runs and stall runs.
   int stall_phase = 0;
   always @(posedge clock) begin
      rsp_item_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_item_type'(rsp_tdata[14:0]);
            if (expected_events.size() == 0) begin
               $display("%0t: unexpected beat %h", $time, rsp_tdata);
               errors++;
            end else begin
               want = expected_events.pop_front();
               checked++;
               event_seen[got.event_res]++;
               if (got.event_res != want.event_res) begin
                  $display("%0t: event_res expected %0d actual %0d",
                           $time, want.event_res, got.event_res);
                  errors++;
               end
               if (got.out_letter != want.out_letter) begin
                  $display("%0t: out_letter expected %0d actual %0d",
                           $time, want.out_letter, got.out_letter);
                  errors++;
               end
               if (got.word_length != want.word_length) begin
                  $display("%0t: word_length expected %0d actual %0d",
                           $time, want.word_length, got.word_length);
                  errors++;
               end
            end
         end
         stall_phase <= (stall_phase + 1) % 97;
         if (stall_phase < 40) rsp_tready <= 1'b1;
         else if (stall_phase < 60) rsp_tready <= 1'b0;
         else rsp_tready <= $urandom_range(0, 2) != 0;
      end
   end

   task automatic add_item(logic [1:0] f, logic [4:0] l, logic [31:0] rv);
      req_item_type it;
      it.func = f; it.letter = l; it.rand_value = rv;
      pending_items.push_back(it);
   endtask

   task automatic drain(int extra);
      wait (pending_items.size() == 0);
      // Let the driver's last update settle before looking at the bus.
      @(posedge clock);
      while (req_tvalid || expected_events.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1; csr_addr <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MIN_LENGTH) min_len = val; else max_len = val;
   endtask

   // Trains a random word of a vowel-rich shape, sometimes with noise.
   task automatic train_word(int len);
      logic [4:0] l;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 4))
               0: l = 5'd0;
               1: l = 5'd4;
               2: l = 5'd8;
               3: l = 5'd14;
               default: l = 5'd20;
            endcase
         end else begin
            l = 5'($urandom_range(0, 25));
         end
         add_item(FUNC_TRAIN_LTR, l, $urandom);
      end
      add_item(FUNC_TRAIN_END, 5'($urandom_range(0, 31)), $urandom);
   endtask

   initial begin
      clear_model();
      min_len = MIN_LENGTH_RST;
      max_len = MAX_LENGTH_RST;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      write_reg(CSR_MIN_LENGTH, 6'd0);
      write_reg(CSR_MAX_LENGTH, 6'd12);

      // Directed: empty context, odd letters, extreme random values, wrap-free
      // short model, rejected ends and a clear.
      add_item(FUNC_GENERATE, 5'd0, 32'hFFFF_FFFF);
      add_item(FUNC_TRAIN_LTR, 5'd31, 32'h0);
      add_item(FUNC_TRAIN_LTR, 5'd26, 32'h0);
      add_item(FUNC_TRAIN_END, 5'd0, 32'h0);
      add_item(FUNC_TRAIN_LTR, 5'd25, 32'h0);
      add_item(FUNC_TRAIN_LTR, 5'd0, 32'h0);
      add_item(FUNC_TRAIN_END, 5'd0, 32'h0);
      add_item(FUNC_TRAIN_LTR, 5'd1, 32'h0);
      add_item(FUNC_TRAIN_END, 5'd0, 32'h0);
      for (int i = 0; i < 12; i++) add_item(FUNC_GENERATE, 5'd0, (i % 2) ? 32'hFFFF_FFFF : 32'(i));
      add_item(FUNC_CLEAR, 5'd31, 32'hFFFF_FFFF);
      add_item(FUNC_GENERATE, 5'd0, 32'h0);
      drain(CLEAR_WAIT);

      // Self-loop model: endless letter to hit the length limit.
      add_item(FUNC_TRAIN_LTR, 5'd0, 32'h0);
      add_item(FUNC_TRAIN_LTR, 5'd0, 32'h0);
      for (int i = 0; i < 4; i++) add_item(FUNC_TRAIN_LTR, 5'd0, 32'h0);
      for (int i = 0; i < 20; i++) add_item(FUNC_GENERATE, 5'd0, $urandom);
      drain(0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin write_reg(CSR_MIN_LENGTH, 6'd63); write_reg(CSR_MAX_LENGTH, 6'd63); end
            1: begin write_reg(CSR_MIN_LENGTH, 6'd2);  write_reg(CSR_MAX_LENGTH, 6'd1);  end
            2: begin write_reg(CSR_MIN_LENGTH, 6'd3);  write_reg(CSR_MAX_LENGTH, 6'd8);  end
            default: begin write_reg(CSR_MIN_LENGTH, 6'd0); write_reg(CSR_MAX_LENGTH, 6'd12); end
         endcase
         add_item(FUNC_CLEAR, 5'($urandom), $urandom);
         drain(CLEAR_WAIT);
         for (int w = 0; w < 25; w++) train_word($urandom_range(1, 6));
         for (int g = 0; g < 237; g++) begin
            if ($urandom_range(0, 19) == 0)
               add_item(($urandom_range(0, 1) == 0) ? FUNC_TRAIN_LTR : FUNC_TRAIN_END,
                        5'($urandom), $urandom);
            else
               add_item(FUNC_GENERATE, 5'($urandom), $urandom);
         end
         if (phase == 1) begin
            wait (pending_items.size() < 100);
            hold_sender = 1'b1;
            @(posedge clock);
            while (req_tvalid || expected_events.size() != 0) @(posedge clock);
            hold_sender = 1'b0;
         end
         drain(0);
      end

      // Final clear, then a quiet stretch before the totals.
      write_reg(CSR_MIN_LENGTH, 6'd0);
      add_item(FUNC_CLEAR, 5'd0, 32'h0);
      drain(CLEAR_WAIT);
      drain(100);

      $display("Summary: %0d beats sent, %0d responses checked, %0d words done.",
               accepted, checked, event_seen[EV_DONE]);
      $display("Events ack/letter/done/reject/restart/empty: %0d/%0d/%0d/%0d/%0d/%0d",
               event_seen[EV_ACK], event_seen[EV_LETTER], event_seen[EV_DONE],
               event_seen[EV_REJECT], event_seen[EV_RESTART], event_seen[EV_EMPTY]);
      if (errors == 0 && expected_events.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
